FILE: hdl/ranged_bit_packer_assert.svh
// Assertion macros shared by the ranged bit packer RTL.
`ifndef RANGED_BIT_PACKER_ASSERT_SVH
`define RANGED_BIT_PACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ranged_bit_packer: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ranged_bit_packer: next-cycle check failed");

`endif

FILE: hdl/rbp_pkg.sv
// Shared types, constants and helper functions of the ranged bit packer.
package rbp_pkg;

  localparam int RAW_BITS   = 32;
  localparam int DIGIT_BITS = 8;
  localparam int NUM_DIGITS = RAW_BITS / DIGIT_BITS;
  localparam int CNT_W      = $clog2(NUM_DIGITS);
  localparam int NBITS_W    = 6;
  localparam int EREM_W     = 3;

  typedef enum logic [1:0] {
    OP_UNSIGNED = 2'd0,
    OP_SIGNED   = 2'd1,
    OP_RAW      = 2'd2,
    OP_FLUSH    = 2'd3
  } rbp_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_ERR,
    ST_PACK,
    ST_FLUSH
  } rbp_state_t;

  // Request to the range unit: start pulse and the three order keys.
  typedef struct packed {
    logic                start;
    logic [RAW_BITS-1:0] kv;
    logic [RAW_BITS-1:0] klo;
    logic [RAW_BITS-1:0] khi;
  } rbp_range_req_t;

  // Range unit result, valid in the cycle that done is high.
  typedef struct packed {
    logic                done;
    logic                err;
    logic [NBITS_W-1:0]  nbits;
    logic [RAW_BITS-1:0] data;
  } rbp_range_res_t;

  // Commands to the chunk packer.
  typedef struct packed {
    logic                load;
    logic                step;
    logic                clear;
    logic [RAW_BITS-1:0] data;
    logic [NBITS_W-1:0]  nbits;
  } rbp_pack_cmd_t;

  // Status of the chunk packer.
  typedef struct packed {
    logic       emit;
    logic       emit_last;
    logic       final_step;
    logic       pending;
    logic [7:0] step_byte;
    logic [7:0] partial;
    logic [2:0] used;
  } rbp_pack_stat_t;

  // Mask of the low n bits of a byte, n from 0 to 8.
  function automatic logic [7:0] mask8(input logic [3:0] n);
    logic [8:0] m;
    m = (9'h1 << n) - 9'h1;
    return m[7:0];
  endfunction

  // Number of significant bits in a byte.
  function automatic logic [3:0] bitlen8(input logic [7:0] b);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        r = 4'(i + 1);
      end
    end
    return r;
  endfunction

endpackage

FILE: hdl/rbp_range_unit.sv
// Byte-serial bounds check, offset subtraction and bit-length search.
module rbp_range_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rbp_pkg::rbp_range_req_t req,
  output rbp_pkg::rbp_range_res_t res
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [rbp_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [rbp_pkg::RAW_BITS-1:0]  kv_r, kv_nxt;
  logic [rbp_pkg::RAW_BITS-1:0]  klo_r, klo_nxt;
  logic [rbp_pkg::RAW_BITS-1:0]  khi_r, khi_nxt;
  logic [rbp_pkg::RAW_BITS-1:0]  data_r, data_nxt;
  logic [rbp_pkg::NBITS_W-1:0]   nbits_r, nbits_nxt;
  logic                          b_vl_r, b_vl_nxt;
  logic                          b_hl_r, b_hl_nxt;
  logic                          b_hv_r, b_hv_nxt;
  logic [8:0]                    d_vl, d_hl, d_hv;

  // One byte of each difference per cycle, least significant byte first.
  always_comb begin
    d_vl = {1'b0, kv_r[7:0]}  - {1'b0, klo_r[7:0]} - {8'd0, b_vl_r};
    d_hl = {1'b0, khi_r[7:0]} - {1'b0, klo_r[7:0]} - {8'd0, b_hl_r};
    d_hv = {1'b0, khi_r[7:0]} - {1'b0, kv_r[7:0]}  - {8'd0, b_hv_r};
  end

  // Sequencing of the four digit steps.
  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    kv_nxt    = kv_r;
    klo_nxt   = klo_r;
    khi_nxt   = khi_r;
    data_nxt  = data_r;
    nbits_nxt = nbits_r;
    b_vl_nxt  = b_vl_r;
    b_hl_nxt  = b_hl_r;
    b_hv_nxt  = b_hv_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      kv_nxt    = req.kv;
      klo_nxt   = req.klo;
      khi_nxt   = req.khi;
      nbits_nxt = '0;
      b_vl_nxt  = 1'b0;
      b_hl_nxt  = 1'b0;
      b_hv_nxt  = 1'b0;
    end else if (busy_r) begin
      kv_nxt   = {8'd0, kv_r[rbp_pkg::RAW_BITS-1:8]};
      klo_nxt  = {8'd0, klo_r[rbp_pkg::RAW_BITS-1:8]};
      khi_nxt  = {8'd0, khi_r[rbp_pkg::RAW_BITS-1:8]};
      data_nxt = {d_vl[7:0], data_r[rbp_pkg::RAW_BITS-1:8]};
      b_vl_nxt = d_vl[8];
      b_hl_nxt = d_hl[8];
      b_hv_nxt = d_hv[8];
      // The highest nonzero byte of the range sets its bit length.
      if (d_hl[7:0] != 8'd0) begin
        nbits_nxt = {1'b0, cnt_r, 3'b000} + {2'b00, rbp_pkg::bitlen8(d_hl[7:0])};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == rbp_pkg::CNT_W'(rbp_pkg::NUM_DIGITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    kv_r    <= kv_nxt;
    klo_r   <= klo_nxt;
    khi_r   <= khi_nxt;
    data_r  <= data_nxt;
    nbits_r <= nbits_nxt;
    b_vl_r  <= b_vl_nxt;
    b_hl_r  <= b_hl_nxt;
    b_hv_r  <= b_hv_nxt;
  end

  // Value below min, value above max, or max not above min.
  always_comb begin
    res.done  = done_r;
    res.err   = b_vl_r | b_hl_r | b_hv_r | (nbits_r == '0);
    res.nbits = nbits_r;
    res.data  = data_r;
  end

endmodule

FILE: hdl/rbp_chunk_packer.sv
// Stream byte assembly: one source byte chunk merged per cycle while step is given.
module rbp_chunk_packer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rbp_pkg::rbp_pack_cmd_t cmd,
  output rbp_pkg::rbp_pack_stat_t stat
);

  logic [7:0]                   partial_r, partial_nxt;
  logic [2:0]                   used_r, used_nxt;
  logic [rbp_pkg::RAW_BITS-1:0] data_r, data_nxt;
  logic [rbp_pkg::NBITS_W-1:0]  rem_r, rem_nxt;
  logic [rbp_pkg::EREM_W-1:0]   erem_r, erem_nxt;
  logic [3:0]                   k, freeb, rest;
  logic [7:0]                   src, hi, step_byte, part_step;
  logic [2:0]                   used_step;
  logic                         emit;
  logic [rbp_pkg::NBITS_W-1:0]  total;

  // Merge the current chunk into the pending byte.
  always_comb begin
    k     = (rem_r > rbp_pkg::NBITS_W'(8)) ? 4'd8 : rem_r[3:0];
    freeb = 4'd8 - {1'b0, used_r};
    src   = data_r[7:0];
    emit  = (k >= freeb);
    rest  = k - freeb;
    hi    = (src >> freeb) & rbp_pkg::mask8(rest);
    step_byte = partial_r | (src & rbp_pkg::mask8(freeb));
    if (emit) begin
      part_step = hi << (4'd8 - rest);
      used_step = rest[2:0];
    end else begin
      part_step = partial_r | ((src & rbp_pkg::mask8(k)) << (freeb - k));
      used_step = used_r + k[2:0];
    end
  end

  // Next state for load, step and clear.
  always_comb begin
    partial_nxt = partial_r;
    used_nxt    = used_r;
    data_nxt    = data_r;
    rem_nxt     = rem_r;
    erem_nxt    = erem_r;
    total       = {3'b000, used_r} + cmd.nbits;
    if (cmd.load) begin
      data_nxt = cmd.data;
      rem_nxt  = cmd.nbits;
      erem_nxt = total[rbp_pkg::NBITS_W-1:3];
    end else if (cmd.step) begin
      partial_nxt = part_step;
      used_nxt    = used_step;
      data_nxt    = {8'd0, data_r[rbp_pkg::RAW_BITS-1:8]};
      rem_nxt     = rem_r - {2'b00, k};
      erem_nxt    = erem_r - {2'b00, emit};
    end else if (cmd.clear) begin
      partial_nxt = '0;
      used_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      used_r    <= '0;
      rem_r     <= '0;
      erem_r    <= '0;
    end else begin
      partial_r <= partial_nxt;
      used_r    <= used_nxt;
      rem_r     <= rem_nxt;
      erem_r    <= erem_nxt;
    end
    data_r <= data_nxt;
  end

  always_comb begin
    stat.emit       = emit;
    stat.emit_last  = (erem_r == rbp_pkg::EREM_W'(1));
    stat.final_step = (rem_r <= rbp_pkg::NBITS_W'(8));
    stat.pending    = (used_r != 3'd0);
    stat.step_byte  = step_byte;
    stat.partial    = partial_r;
    stat.used       = used_r;
  end

endmodule

FILE: hdl/ranged_bit_packer.sv
// Ranged bit packer top level: control sequencer and output register.
//
// Input channel (in_*): one transfer carries an opcode in in_tuser and the
// value, min and max words in in_tdata. in_tready is high only while the
// block is idle; one item is worked on at a time.
// Output channel (out_*): one transfer per stream byte, an error marker or
// a flushed partial byte; out_tlast marks the final result of an item.
// Sequence of one item, from the accepting edge to being ready again:
//   raw write      load, then one 8-bit chunk per cycle while the output is free,
//   ranged write   byte-serial range check, then load and the chunks of n bits
//                  as for a raw write, n the bit length of max - min;
//   range error    range check, then the error marker; flush: the partial byte, if any.
// The chunk merger emits at most one byte per cycle into a single output
// register; when out_tready is low that register holds its transfer and
// the chunk sequencer waits, so nothing is lost or repeated.
// Synchronous reset clears the pending partial byte, the fill count, the
// sequencer and the output valid flag.
module ranged_bit_packer #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // value[31:0], min_value[63:32], max_value[95:64]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_byte[7:0], valid_bits[11:8], zero fill[15:12]
  output logic        out_tuser,  // range_error
  output logic        out_tlast   // last
);

  `include "ranged_bit_packer_assert.svh"

  localparam int         EW       = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
  localparam logic [63:0] MASK64  = (64'h1 << EW) - 64'h1;
  localparam logic [63:0] SIGN64  = 64'h1 << (EW - 1);
  localparam logic [31:0] VMASK   = MASK64[31:0];
  localparam logic [31:0] SIGNBIT = SIGN64[31:0];

  rbp_pkg::rbp_state_t     state_r, state_nxt;
  rbp_pkg::rbp_op_t        op;
  rbp_pkg::rbp_range_req_t rng_req;
  rbp_pkg::rbp_range_res_t rng_res;
  rbp_pkg::rbp_pack_cmd_t  pk_cmd;
  rbp_pkg::rbp_pack_stat_t pk_stat;

  logic        in_acc;
  logic        out_free;
  logic [31:0] flip;
  logic        out_load;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic [3:0]  valid_bits_r, valid_bits_nxt;
  logic        err_r, err_nxt;
  logic        last_r, last_nxt;

  assign in_tready = (state_r == rbp_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign op        = rbp_pkg::rbp_op_t'(in_tuser);

  // Sequencer: next state, unit commands and output register loads.
  always_comb begin
    // Order keys: the sign bit is flipped so signed order becomes unsigned order.
    flip           = (op == rbp_pkg::OP_SIGNED) ? SIGNBIT : 32'd0;
    rng_req.kv     = (in_tdata[31:0]  & VMASK) ^ flip;
    rng_req.klo    = (in_tdata[63:32] & VMASK) ^ flip;
    rng_req.khi    = (in_tdata[95:64] & VMASK) ^ flip;
    state_nxt      = state_r;
    rng_req.start  = 1'b0;
    pk_cmd         = '0;
    out_load       = 1'b0;
    out_byte_nxt   = 8'd0;
    valid_bits_nxt = 4'd0;
    err_nxt        = 1'b0;
    last_nxt       = 1'b0;
    case (state_r)
      rbp_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (op)
            rbp_pkg::OP_FLUSH: begin
              state_nxt = rbp_pkg::ST_FLUSH;
            end
            rbp_pkg::OP_RAW: begin
              pk_cmd.load  = 1'b1;
              pk_cmd.data  = in_tdata[31:0];
              pk_cmd.nbits = rbp_pkg::NBITS_W'(rbp_pkg::RAW_BITS);
              state_nxt    = rbp_pkg::ST_PACK;
            end
            default: begin
              rng_req.start = 1'b1;
              state_nxt     = rbp_pkg::ST_RANGE;
            end
          endcase
        end
      end
      rbp_pkg::ST_RANGE: begin
        if (rng_res.done) begin
          if (rng_res.err) begin
            state_nxt = rbp_pkg::ST_ERR;
          end else begin
            pk_cmd.load  = 1'b1;
            pk_cmd.data  = rng_res.data;
            pk_cmd.nbits = rng_res.nbits;
            state_nxt    = rbp_pkg::ST_PACK;
          end
        end
      end
      rbp_pkg::ST_ERR: begin
        if (out_free) begin
          out_load  = 1'b1;
          err_nxt   = 1'b1;
          last_nxt  = 1'b1;
          state_nxt = rbp_pkg::ST_IDLE;
        end
      end
      rbp_pkg::ST_PACK: begin
        if (out_free) begin
          pk_cmd.step = 1'b1;
          if (pk_stat.emit) begin
            out_load       = 1'b1;
            out_byte_nxt   = pk_stat.step_byte;
            valid_bits_nxt = 4'd8;
            last_nxt       = pk_stat.emit_last;
          end
          if (pk_stat.final_step) begin
            state_nxt = rbp_pkg::ST_IDLE;
          end
        end
      end
      rbp_pkg::ST_FLUSH: begin
        if (!pk_stat.pending) begin
          state_nxt = rbp_pkg::ST_IDLE;
        end else if (out_free) begin
          out_load       = 1'b1;
          out_byte_nxt   = pk_stat.partial;
          valid_bits_nxt = {1'b0, pk_stat.used};
          last_nxt       = 1'b1;
          pk_cmd.clear   = 1'b1;
          state_nxt      = rbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rbp_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid flag: set on load, cleared once the transfer completes.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rbp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (out_load) begin
      out_byte_r   <= out_byte_nxt;
      valid_bits_r <= valid_bits_nxt;
      err_r        <= err_nxt;
      last_r       <= last_nxt;
    end
  end

  rbp_range_unit u_range (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rng_req),
    .res   (rng_res)
  );

  rbp_chunk_packer u_packer (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (pk_cmd),
    .stat  (pk_stat)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, valid_bits_r, out_byte_r};
  assign out_tuser  = err_r;
  assign out_tlast  = last_r;

  // An error result carries no bits and always closes its item.
  `RBP_ASSERT_SAME(a_err_shape, clk, rst_n, out_valid_r && err_r, valid_bits_r == 4'd0 && last_r)
  // A short byte only comes from a flush, which is always the final result.
  `RBP_ASSERT_SAME(a_short_is_last, clk, rst_n, out_valid_r && !err_r && valid_bits_r != 4'd8, last_r)
  // An accepted item always takes the block out of idle.
  `RBP_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_acc, !in_tready)
  // The pending byte stays put while the range check runs.
  `RBP_ASSERT_NEXT(a_range_holds, clk, rst_n, state_r == rbp_pkg::ST_RANGE, $stable(pk_stat.used) && $stable(pk_stat.partial))

endmodule
